/* hw/rtl/direct_dft_unitary_core_defines.svh */
// ---------------------------------------------------------------------------
// direct_dft_unitary_core_defines.svh
// Assertion macros shared by the DFT core.
// ---------------------------------------------------------------------------
`ifndef DIRECT_DFT_UNITARY_CORE_DEFINES_SVH
`define DIRECT_DFT_UNITARY_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define DDU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DDU_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/ddu_pkg.sv */
// ---------------------------------------------------------------------------
// ddu_pkg
// Sizes, twiddle ROM, scale constant and shared types of the DFT core.
// ---------------------------------------------------------------------------
package ddu_pkg;

	localparam int POINTS = 64;
	localparam int IDX_W  = (POINTS > 1) ? $clog2(POINTS) : 1;
	localparam int BIN_W  = 6;
	localparam int SAMP_W = 16;
	localparam int WORD_W = 2 * SAMP_W;
	localparam int PR_W   = 2 * SAMP_W + 1;
	localparam int ACC_W  = PR_W + IDX_W + 1;

	typedef logic [POINTS-1:0][WORD_W-1:0] tw_rom_t;

	// memory port requests from the sequencer
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} ddu_mem_req_t;

	// one MAC issue: twiddle phase, bin number and bin boundary flags
	typedef struct packed {
		logic             vld;
		logic             first;
		logic             last;
		logic [IDX_W-1:0] ph;
		logic [IDX_W-1:0] bin;
	} ddu_issue_t;

	localparam longint ATAN_TAB [30] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
		10, 5, 3, 1
	};

	function automatic longint ddu_sat16(input longint v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	// integer CORDIC, one entry per phase step; word = {sin, cos} in Q1.15
	function automatic tw_rom_t ddu_tw_build();
		tw_rom_t     rom;
		longint      ph64;
		logic [31:0] phase;
		logic [1:0]  quad;
		longint      x, y, z, dx, dy, cv, sv, c, s;
		for (int idx = 0; idx < POINTS; idx++) begin
			ph64  = (longint'(idx) <<< 32) / POINTS;
			phase = ph64[31:0];
			quad  = phase[31:30];
			z     = longint'({2'b00, phase[29:0]});
			x     = 652032875;
			y     = 0;
			for (int i = 0; i < 30; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x = x - dx;
					y = y + dy;
					z = z - ATAN_TAB[i];
				end else begin
					x = x + dx;
					y = y - dy;
					z = z + ATAN_TAB[i];
				end
			end
			cv = ddu_sat16((x + 16384) >>> 15);
			sv = ddu_sat16((y + 16384) >>> 15);
			case (quad)
				2'd0: begin c = cv;  s = sv;  end
				2'd1: begin c = -sv; s = cv;  end
				2'd2: begin c = -cv; s = -sv; end
				default: begin c = sv; s = -cv; end
			endcase
			rom[idx] = {s[SAMP_W-1:0], c[SAMP_W-1:0]};
		end
		return rom;
	endfunction

	function automatic longint unsigned ddu_isqrt(input longint unsigned v);
		longint unsigned r, b, rem;
		r   = 0;
		b   = 64'd1 << 62;
		rem = v;
		while (b > rem)
			b = b >> 2;
		while (b != 0) begin
			if (rem >= r + b) begin
				rem = rem - (r + b);
				r   = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	localparam tw_rom_t TW_ROM = ddu_tw_build();

	// round(sqrt(2^30 / POINTS)) in Q1.15
	localparam int              SCALE_W = 16;
	localparam longint unsigned SCALE_L = (ddu_isqrt((64'd1 << 32) / POINTS) + 1) >> 1;
	localparam logic signed [SCALE_W:0] SCALE = {1'b0, SCALE_L[SCALE_W-1:0]};
	localparam int PROD_W    = ACC_W + SCALE_W + 1;
	localparam int RND_SHIFT = 30;

endpackage

/* hw/rtl/direct_dft_unitary_core.sv */
// ---------------------------------------------------------------------------
// direct_dft_unitary_core
// Direct-form DFT with unitary scaling over blocks of POINTS complex samples.
// ---------------------------------------------------------------------------
// Samples come in one per transfer (start high while busy is low) and land in
// the sample RAM. The transfer that completes a block raises busy; the core
// then runs POINTS x POINTS complex multiply-accumulates, one per clock, using
// the single read port of the sample RAM, and emits one bin after each run of
// POINTS accumulations on out_* with out_valid high for exactly one cycle. The
// receiver cannot stall: every strobe is a transfer and must be taken. last_bin
// marks bin POINTS-1; busy drops on the same edge that bin appears, so the next
// block's first sample may be taken while it is still on the outputs.
// Compute speed is set by the one-read-per-cycle RAM port feeding one MAC.
// Direction (cfg_wdata: 1 forward, 0 inverse) may only change while idle.
// Output rounding is to nearest with ties up, saturated to Q1.15.
// ---------------------------------------------------------------------------
`include "direct_dft_unitary_core_defines.svh"

module direct_dft_unitary_core import ddu_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	// sample input
	input  logic                     start,
	output logic                     busy,
	input  logic signed [SAMP_W-1:0] sample_re,
	input  logic signed [SAMP_W-1:0] sample_im,
	// direction register
	input  logic                     cfg_we,
	input  logic                     cfg_wdata,
	// bin output
	output logic                     out_valid,
	output logic signed [SAMP_W-1:0] out_re,
	output logic signed [SAMP_W-1:0] out_im,
	output logic [BIN_W-1:0]         bin_index,
	output logic                     last_bin
);

	logic              forward_q;
	ddu_mem_req_t      mem_req;
	ddu_issue_t        issue;
	logic [WORD_W-1:0] rdata_s1;
	logic              done;

	// forward resets to 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			forward_q <= 1'b1;
		else if (cfg_we)
			forward_q <= cfg_wdata;
	end

	ddu_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.done   (done),
		.busy   (busy),
		.req    (mem_req),
		.issue  (issue)
	);

	// RAM word: imaginary part high, real part low
	ddu_store u_store (
		.clk      (clk),
		.req      (mem_req),
		.wdata    ({sample_im, sample_re}),
		.rdata_s1 (rdata_s1)
	);

	ddu_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.forward   (forward_q),
		.issue     (issue),
		.rdata_s1  (rdata_s1),
		.done      (done),
		.out_valid (out_valid),
		.out_re    (out_re),
		.out_im    (out_im),
		.bin_index (bin_index),
		.last_bin  (last_bin)
	);

	// busy only rises from a sample transfer
	`DDU_ASSERT_NOW(a_busy_rise, $rose(busy), $past(start), "busy rose without a transfer")
	// bins before the last one come out while the block is still in flight
	`DDU_ASSERT_NOW(a_mid_busy, out_valid && !last_bin, busy, "bin emitted while idle")
	// the final bin releases the core
	`DDU_ASSERT_NOW(a_last_idle, out_valid && last_bin, !busy, "still busy at last bin")
	// bins are spaced by the inner loop, never adjacent
	`DDU_ASSERT_NXT(a_strobe_gap, out_valid, !out_valid, "back-to-back bin strobes")

endmodule

/* hw/rtl/ddu_store.sv */
// ---------------------------------------------------------------------------
// ddu_store
// Sample RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module ddu_store import ddu_pkg::*; (
	input  logic               clk,
	input  ddu_mem_req_t       req,
	input  logic [WORD_W-1:0]  wdata,
	output logic [WORD_W-1:0]  rdata_s1
);

	logic [WORD_W-1:0] mem [POINTS];

	always_ff @(posedge clk) begin
		if (req.we)
			mem[req.waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (req.re)
			rdata_s1 <= mem[req.raddr];
	end

endmodule

/* hw/rtl/ddu_seq.sv */
// ---------------------------------------------------------------------------
// ddu_seq
// Fill counter, busy flag and the bin/sample issue counters.
// ---------------------------------------------------------------------------
module ddu_seq import ddu_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic         done,
	output logic         busy,
	output ddu_mem_req_t req,
	output ddu_issue_t   issue
);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POINTS - 1);
	localparam logic [IDX_W:0]   PTS_EXT  = (IDX_W + 1)'(POINTS);

	logic             busy_q, run_q;
	logic [IDX_W-1:0] fill_q, n_q, k_q, ph_q;
	logic             take;
	logic [IDX_W:0]   ph_sum;

	assign take   = start & ~busy_q;
	assign ph_sum = {1'b0, ph_q} + {1'b0, n_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			run_q  <= 1'b0;
			fill_q <= '0;
			n_q    <= '0;
			k_q    <= '0;
			ph_q   <= '0;
		end else begin
			if (take) begin
				if (fill_q == LAST_IDX) begin
					fill_q <= '0;
					busy_q <= 1'b1;
					run_q  <= 1'b1;
					n_q    <= '0;
					k_q    <= '0;
					ph_q   <= '0;
				end else begin
					fill_q <= fill_q + 1'b1;
				end
			end else if (run_q) begin
				if (k_q == LAST_IDX) begin
					k_q  <= '0;
					ph_q <= '0;
					n_q  <= n_q + 1'b1;
					if (n_q == LAST_IDX)
						run_q <= 1'b0;
				end else begin
					k_q  <= k_q + 1'b1;
					// phase = n*k mod POINTS, stepped by n
					ph_q <= (ph_sum >= PTS_EXT) ? IDX_W'(ph_sum - PTS_EXT) : ph_sum[IDX_W-1:0];
				end
			end
			if (done)
				busy_q <= 1'b0;
		end
	end

	assign busy = busy_q;

	always_comb begin
		req.we      = take;
		req.waddr   = fill_q;
		req.re      = run_q;
		req.raddr   = k_q;
		issue.vld   = run_q;
		issue.first = (k_q == '0);
		issue.last  = (k_q == LAST_IDX);
		issue.ph    = ph_q;
		issue.bin   = n_q;
	end

endmodule

/* hw/rtl/ddu_mac.sv */
// ---------------------------------------------------------------------------
// ddu_mac
// Twiddle lookup, complex multiply, accumulate, scale, round and saturate.
// ---------------------------------------------------------------------------
module ddu_mac import ddu_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     forward,
	input  ddu_issue_t               issue,
	input  logic [WORD_W-1:0]        rdata_s1,
	output logic                     done,
	output logic                     out_valid,
	output logic signed [SAMP_W-1:0] out_re,
	output logic signed [SAMP_W-1:0] out_im,
	output logic [BIN_W-1:0]         bin_index,
	output logic                     last_bin
);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POINTS - 1);
	localparam int RND_W = PROD_W - RND_SHIFT;
	localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(64'd1 << (RND_SHIFT - 1));
	localparam logic signed [RND_W-1:0]  SAT_HI   = RND_W'(32767);
	localparam logic signed [RND_W-1:0]  SAT_LO   = -RND_W'(32768);

	// s1: twiddle, aligned with RAM read data
	ddu_issue_t               iss_s1;
	logic signed [SAMP_W-1:0] c_s1, s_s1;
	logic [WORD_W-1:0]        tw_word;

	assign tw_word = TW_ROM[issue.ph];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			iss_s1 <= '0;
		else
			iss_s1 <= issue;
	end

	always_ff @(posedge clk) begin
		c_s1 <= tw_word[SAMP_W-1:0];
		s_s1 <= forward ? -$signed(tw_word[WORD_W-1:SAMP_W]) : $signed(tw_word[WORD_W-1:SAMP_W]);
	end

	// s2: products
	logic signed [SAMP_W-1:0] xr, xi;
	logic signed [WORD_W-1:0] m_rr, m_ii, m_rs, m_ic;
	logic signed [PR_W-1:0]   pr_re_s2, pr_im_s2;
	logic                     vld_s2, first_s2, last_s2;
	logic [IDX_W-1:0]         bin_s2;

	assign xr   = rdata_s1[SAMP_W-1:0];
	assign xi   = rdata_s1[WORD_W-1:SAMP_W];
	assign m_rr = xr * c_s1;
	assign m_ii = xi * s_s1;
	assign m_rs = xr * s_s1;
	assign m_ic = xi * c_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else
			vld_s2 <= iss_s1.vld;
	end

	always_ff @(posedge clk) begin
		pr_re_s2 <= {m_rr[WORD_W-1], m_rr} - {m_ii[WORD_W-1], m_ii};
		pr_im_s2 <= {m_rs[WORD_W-1], m_rs} + {m_ic[WORD_W-1], m_ic};
		first_s2 <= iss_s1.first;
		last_s2  <= iss_s1.last;
		bin_s2   <= iss_s1.bin;
	end

	// s3: accumulators
	logic signed [ACC_W-1:0] acc_re_q, acc_im_q;
	logic signed [ACC_W-1:0] add_re, add_im;
	logic                    acc_done_s3;
	logic [IDX_W-1:0]        bin_s3;

	assign add_re = {{(ACC_W-PR_W){pr_re_s2[PR_W-1]}}, pr_re_s2};
	assign add_im = {{(ACC_W-PR_W){pr_im_s2[PR_W-1]}}, pr_im_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			acc_done_s3 <= 1'b0;
		else
			acc_done_s3 <= vld_s2 & last_s2;
	end

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			acc_re_q <= first_s2 ? add_re : acc_re_q + add_re;
			acc_im_q <= first_s2 ? add_im : acc_im_q + add_im;
		end
		bin_s3 <= bin_s2;
	end

	// s4: unitary scale (constant multiply)
	logic signed [PROD_W-1:0] sc_re_s4, sc_im_s4;
	logic                     vld_s4;
	logic [IDX_W-1:0]         bin_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s4 <= 1'b0;
		else
			vld_s4 <= acc_done_s3;
	end

	always_ff @(posedge clk) begin
		sc_re_s4 <= acc_re_q * SCALE;
		sc_im_s4 <= acc_im_q * SCALE;
		bin_s4   <= bin_s3;
	end

	// s5: round half up, saturate, present
	logic signed [PROD_W-1:0] rs_re, rs_im;
	logic signed [RND_W-1:0]  rn_re, rn_im;
	logic                     is_last;

	assign rs_re   = (sc_re_s4 + RND_HALF) >>> RND_SHIFT;
	assign rs_im   = (sc_im_s4 + RND_HALF) >>> RND_SHIFT;
	assign rn_re   = rs_re[RND_W-1:0];
	assign rn_im   = rs_im[RND_W-1:0];
	assign is_last = (bin_s4 == LAST_IDX);
	assign done    = vld_s4 & is_last;

	function automatic logic signed [SAMP_W-1:0] sat(input logic signed [RND_W-1:0] v);
		if (v > SAT_HI)
			return SAMP_W'(16'sh7FFF);
		if (v < SAT_LO)
			return SAMP_W'(16'sh8000);
		return v[SAMP_W-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else
			out_valid <= vld_s4;
	end

	always_ff @(posedge clk) begin
		out_re    <= sat(rn_re);
		out_im    <= sat(rn_im);
		bin_index <= BIN_W'(bin_s4);
		last_bin  <= is_last;
	end

endmodule
